/* rtl/ucbo_pkg.sv */
// ----------------------------------------------------------------------------
// ucbo_pkg
// Shared constants, codes and helpers of the UTF-8 code point to byte offset
// unit.
// ----------------------------------------------------------------------------
package ucbo_pkg;

	localparam int MAX_RECORD_BYTES = 4096;
	localparam int ADDR_W           = $clog2(MAX_RECORD_BYTES);
	localparam int OFF_W            = 13;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_FWD  = 2'd1;
	localparam logic [1:0] CMD_BACK = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_WALK,
		ST_DONE
	} ucbo_state_t;

	// continuation bytes announced by a lead byte
	function automatic logic [1:0] lead_more(input logic [7:0] b);
		logic [1:0] m;
		m = 2'd0;
		if (b >= 8'hC0 && b < 8'hE0) m = 2'd1;
		else if (b >= 8'hE0 && b < 8'hF0) m = 2'd2;
		else if (b >= 8'hF0 && b < 8'hF8) m = 2'd3;
		return m;
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

endpackage

/* rtl/ucbo_if.sv */
// ----------------------------------------------------------------------------
// ucbo_if
// Valid/ready channels of the unit: request channel and result channel.
// ----------------------------------------------------------------------------
interface ucbo_req_if import ucbo_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       cmd;
	logic [7:0]       data_byte;
	logic             last_byte;
	logic [OFF_W-1:0] query_position;

	modport source(output valid, cmd, data_byte, last_byte, query_position, input ready);
	modport sink(input valid, cmd, data_byte, last_byte, query_position, output ready);
endinterface

interface ucbo_rsp_if import ucbo_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OFF_W-1:0] byte_offset;

	modport source(output valid, byte_offset, input ready);
	modport sink(input valid, byte_offset, output ready);
endinterface

/* rtl/utf8_codepoint_to_byte_offset_unit.sv */
// ----------------------------------------------------------------------------
// utf8_codepoint_to_byte_offset_unit
// Holds one UTF-8 record and turns code point positions into byte offsets.
// ----------------------------------------------------------------------------
// A load transfer writes one byte into the record store while it has room;
// the transfer with last_byte set closes the record and clears both position
// caches. A query takes one item at a time. An immediate answer (position
// zero or an all-ASCII record) goes from the decide state to the done state;
// otherwise the unit walks from the nearest cached point or record edge,
// reading the single-port record store one byte per cycle. The result
// sits in an output register, so a new request is taken while it waits.
module utf8_codepoint_to_byte_offset_unit import ucbo_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ucbo_req_if.sink   req,
	ucbo_rsp_if.source rsp
);

	logic [7:0]        store_mem [MAX_RECORD_BYTES];
	logic [7:0]        rdata_q;
	logic [ADDR_W-1:0] raddr;
	logic              wr_en;

	ucbo_state_t state_q, state_n;

	logic [OFF_W-1:0] len_q, lp_q, lp_inc;
	logic             all_ascii_q, run_q, run_n;
	logic [OFF_W-1:0] fc_pts_q, fc_off_q, bc_pts_q, bc_off_q;

	logic             qfwd_q, fwd_q, up_q, cont_q, cont_n;
	logic [OFF_W-1:0] want_q, b_q, b_n, cp_q, cp_n, res_q, res_n;
	logic [1:0]       cnt_q, cnt_n;
	logic             walk_done;

	logic             out_valid_q;
	logic [OFF_W-1:0] out_off_q;

	logic req_xfer, load_xfer, query_xfer, out_load;

	// start point selection
	logic [OFF_W-1:0] cache_cp, cache_off, edge_off, diff, start_b, start_cp, imm_res;
	logic             near, use_c, imm;

	// walk datapath
	logic cnt_ok, bnd_ok, in_cont;

	assign req.ready  = (state_q == ST_IDLE);
	assign req_xfer   = req.valid && req.ready;
	assign load_xfer  = req_xfer && (req.cmd == CMD_LOAD);
	assign query_xfer = req_xfer && (req.cmd == CMD_FWD || req.cmd == CMD_BACK);

	assign wr_en  = load_xfer && (lp_q < OFF_W'(MAX_RECORD_BYTES));
	assign lp_inc = lp_q + {{(OFF_W-1){1'b0}}, wr_en};
	assign run_n  = run_q & ~(wr_en & req.data_byte[7]);

	always_comb begin
		cache_cp  = qfwd_q ? fc_pts_q : bc_pts_q;
		cache_off = qfwd_q ? fc_off_q : bc_off_q;
		edge_off  = qfwd_q ? '0 : len_q;
		diff      = cache_cp - want_q;
		near      = (cache_cp != '0) && (want_q < cache_cp) && (diff < want_q);
		use_c     = (cache_cp != '0) && (!(want_q < cache_cp) || near);
		start_b   = use_c ? cache_off : edge_off;
		start_cp  = use_c ? cache_cp : '0;
		imm       = (want_q == '0) || all_ascii_q;
		if (want_q == '0) begin
			imm_res = edge_off;
		end else if (qfwd_q) begin
			imm_res = (want_q < len_q) ? want_q : len_q;
		end else begin
			imm_res = (want_q < len_q) ? (len_q - want_q) : '0;
		end
	end

	always_comb begin
		cnt_ok  = up_q ? (cp_q < want_q) : (cp_q > want_q);
		bnd_ok  = fwd_q ? (b_q < len_q) : (b_q != '0);
		in_cont = cont_q && (cnt_q != 2'd0) && bnd_ok && is_cont(rdata_q);
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	always_comb begin
		state_n   = state_q;
		b_n       = b_q;
		cp_n      = cp_q;
		cnt_n     = cnt_q;
		cont_n    = cont_q;
		res_n     = res_q;
		walk_done = 1'b0;
		raddr     = b_q[ADDR_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (query_xfer) state_n = ST_DECIDE;
			end
			ST_DECIDE: begin
				raddr = start_b[ADDR_W-1:0];
				if (imm) begin
					res_n   = imm_res;
					state_n = ST_DONE;
				end else begin
					b_n     = start_b;
					cp_n    = start_cp;
					cont_n  = 1'b0;
					state_n = ST_WALK;
				end
			end
			ST_WALK: begin
				if (in_cont) begin
					// still inside the current code point
					b_n   = fwd_q ? b_q + OFF_W'(1) : b_q - OFF_W'(1);
					cnt_n = cnt_q - 2'd1;
				end else if (cnt_ok && bnd_ok) begin
					// the byte here opens the next step
					b_n    = fwd_q ? b_q + OFF_W'(1) : b_q - OFF_W'(1);
					cp_n   = up_q ? cp_q + OFF_W'(1) : cp_q - OFF_W'(1);
					cnt_n  = fwd_q ? lead_more(rdata_q) : 2'd3;
					cont_n = 1'b1;
				end else begin
					walk_done = 1'b1;
					res_n     = b_q;
					state_n   = ST_DONE;
				end
				raddr = b_n[ADDR_W-1:0];
			end
			ST_DONE: begin
				if (out_load) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[lp_q[ADDR_W-1:0]] <= req.data_byte;
		end
		rdata_q <= store_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			lp_q        <= '0;
			all_ascii_q <= 1'b1;
			run_q       <= 1'b1;
			fc_pts_q    <= '0;
			fc_off_q    <= '0;
			bc_pts_q    <= '0;
			bc_off_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_xfer) begin
				if (req.last_byte) begin
					len_q       <= lp_inc;
					lp_q        <= '0;
					all_ascii_q <= run_n;
					run_q       <= 1'b1;
					fc_pts_q    <= '0;
					fc_off_q    <= '0;
					bc_pts_q    <= '0;
					bc_off_q    <= lp_inc;
				end else begin
					lp_q  <= lp_inc;
					run_q <= run_n;
				end
			end
			if (walk_done) begin
				// a finished walk updates the cache of its direction; a walk back toward the cached side records the asked position
				if (qfwd_q) begin
					fc_pts_q <= up_q ? cp_q : want_q;
					fc_off_q <= b_q;
				end else begin
					bc_pts_q <= up_q ? cp_q : want_q;
					bc_off_q <= b_q;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query_xfer) begin
			qfwd_q <= (req.cmd == CMD_FWD);
			want_q <= req.query_position;
		end
		if (state_q == ST_DECIDE) begin
			up_q  <= !near;
			fwd_q <= qfwd_q ^ near;
		end
		b_q    <= b_n;
		cp_q   <= cp_n;
		cnt_q  <= cnt_n;
		cont_q <= cont_n;
		res_q  <= res_n;
		if (out_load) begin
			out_off_q <= res_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.byte_offset = out_off_q;

	// a walk never leaves the record
	a_walk_in_record: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (b_q <= len_q))
		else $error("walk offset beyond record length");

	// a query transfer blocks the request side until its result is parked
	a_query_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		query_xfer |=> !req.ready)
		else $error("request taken while a query is in progress");

	// the result register is filled only from the done state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result appeared without a finished query");

	// cached offsets stay inside the record
	a_cache_in_record: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (fc_off_q <= len_q && bc_off_q <= len_q))
		else $error("cached offset beyond record length");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 code point to byte offset unit. Records
// are loaded byte by byte and queried in both directions. A predictor with its
// own record store and position caches works out every offset, and the
// results are checked in order.
// ----------------------------------------------------------------------------
module tb;
	import ucbo_pkg::*;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int RANDOM_ITEMS = 850;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int TAIL_CYCLES  = 40;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 600;
	localparam int POS_TOP      = 4096;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [7:0]       data_byte;
		logic             last_byte;
		logic [OFF_W-1:0] query_position;
	} req_item_t;

	logic clk;
	logic arst_n;

	ucbo_req_if req ();
	ucbo_rsp_if rsp ();

	utf8_codepoint_to_byte_offset_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------------
	// predictor state
	// ------------------------------------------------------------------------
	logic [7:0]  rec_mem [MAX_RECORD_BYTES];
	int unsigned rec_len    = 0;
	int unsigned wr_ptr     = 0;
	bit          ascii_only = 1'b1;
	int unsigned fc_pts     = 0;
	int unsigned fc_off     = 0;
	int unsigned bc_pts     = 0;
	int unsigned bc_off     = 0;

	function automatic int unsigned next_boundary(input int unsigned p);
		int unsigned more;
		logic [7:0]  lead;
		lead = rec_mem[p];
		if (lead < 8'hC0) more = 0;
		else if (lead < 8'hE0) more = 1;
		else if (lead < 8'hF0) more = 2;
		else if (lead < 8'hF8) more = 3;
		else more = 0;
		p++;
		while (more > 0 && p < rec_len && rec_mem[p][7:6] == 2'b10) begin
			p++;
			more--;
		end
		return p;
	endfunction

	function automatic int unsigned prev_boundary(input int unsigned p);
		int unsigned extra;
		extra = 0;
		p--;
		while (extra < 3 && p > 0 && rec_mem[p][7:6] == 2'b10) begin
			p--;
			extra++;
		end
		return p;
	endfunction

	function automatic int unsigned fwd_offset(input int unsigned want);
		int unsigned cp;
		int unsigned b;
		cp = 0;
		b  = 0;
		if (want == 0) return 0;
		if (ascii_only) return (want < rec_len) ? want : rec_len;
		if (fc_pts > 0) begin
			if (want < fc_pts) begin
				// cache is nearer than the start: walk back from it
				if (fc_pts - want < want) begin
					cp = fc_pts;
					b  = fc_off;
					while (cp > want && b > 0) begin
						b = prev_boundary(b);
						cp--;
					end
					fc_pts = want;
					fc_off = b;
					return b;
				end
			end else begin
				cp = fc_pts;
				b  = fc_off;
			end
		end
		while (cp < want && b < rec_len) begin
			b = next_boundary(b);
			cp++;
		end
		fc_pts = cp;
		fc_off = b;
		return b;
	endfunction

	function automatic int unsigned back_offset(input int unsigned want);
		int unsigned cp;
		int unsigned b;
		cp = 0;
		b  = rec_len;
		if (want == 0) return rec_len;
		if (ascii_only) return (want < rec_len) ? rec_len - want : 0;
		if (bc_pts > 0) begin
			if (want < bc_pts) begin
				if (bc_pts - want < want) begin
					cp = bc_pts;
					b  = bc_off;
					while (cp > want && b < rec_len) begin
						b = next_boundary(b);
						cp--;
					end
					bc_pts = want;
					bc_off = b;
					return b;
				end
			end else begin
				cp = bc_pts;
				b  = bc_off;
			end
		end
		while (cp < want && b > 0) begin
			b = prev_boundary(b);
			cp++;
		end
		bc_pts = cp;
		bc_off = b;
		return b;
	endfunction

	function automatic void take_byte(input logic [7:0] d, input logic last);
		int unsigned i;
		// a full store drops the byte but the pointer stays saturated
		if (wr_ptr < MAX_RECORD_BYTES) begin
			rec_mem[wr_ptr] = d;
			wr_ptr++;
		end
		if (last) begin
			rec_len    = wr_ptr;
			wr_ptr     = 0;
			ascii_only = 1'b1;
			for (i = 0; i < rec_len; i++)
				if (rec_mem[i][7]) ascii_only = 1'b0;
			fc_pts = 0;
			fc_off = 0;
			bc_pts = 0;
			bc_off = rec_len;
		end
	endfunction

	// ------------------------------------------------------------------------
	// stimulus generation
	// ------------------------------------------------------------------------
	req_item_t        request_backlog[$];
	logic [OFF_W-1:0] expected_offsets[$];
	int               n_total   = 0;
	int               n_noise   = 0;
	int               n_taken   = 0;
	int               n_bad     = 0;
	int               gen_cps   = 0;
	int               gen_fwd   = 0;
	int               gen_back  = 0;

	task automatic push_item(input logic [1:0] c, input logic [7:0] d, input logic l,
			input int p);
		req_item_t it;
		it.cmd            = c;
		it.data_byte      = d;
		it.last_byte      = l;
		it.query_position = OFF_W'(p);
		request_backlog.push_back(it);
		n_total++;
	endtask

	// unused fields carry random values
	task automatic push_load(input logic [7:0] d, input logic l);
		push_item(CMD_LOAD, d, l, $urandom_range(0, POS_TOP));
	endtask

	task automatic push_query(input logic [1:0] c, input int p);
		push_item(c, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), p);
	endtask

	task automatic add_char(inout logic [7:0] bytes[$], input int kind);
		case (kind)
			0: bytes.push_back(8'($urandom_range(0, 127)));
			1: begin
				bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
				bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
			end
			2: begin
				bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
				repeat (2) bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
			end
			default: begin
				bytes.push_back(8'hF0 | 8'($urandom_range(0, 7)));
				repeat (3) bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
			end
		endcase
	endtask

	// flavour 0 plain ascii, 1 well-formed mix, 2 mix with bytes trashed
	task automatic push_record(input int n_cp, input int flavour);
		logic [7:0] bytes[$];
		int         k;
		for (k = 0; k < n_cp; k++)
			add_char(bytes, (flavour == 0) ? 0 : $urandom_range(0, 3));
		if (flavour == 2)
			repeat ($urandom_range(1, 4))
				bytes[$urandom_range(0, bytes.size() - 1)] = 8'($urandom_range(0, 255));
		for (k = 0; k < bytes.size(); k++) begin
			// now and then a query lands in the middle of a load
			if ($urandom_range(0, 24) == 0)
				push_query($urandom_range(0, 1) ? CMD_FWD : CMD_BACK,
						$urandom_range(0, gen_cps + 2));
			push_load(bytes[k], k == bytes.size() - 1);
		end
		gen_cps  = n_cp;
		gen_fwd  = 0;
		gen_back = 0;
	endtask

	task automatic push_queries(input int n);
		int         i;
		int         r;
		int         p;
		logic [1:0] c;
		for (i = 0; i < n; i++) begin
			c = $urandom_range(0, 1) ? CMD_FWD : CMD_BACK;
			r = $urandom_range(0, 9);
			if (r == 0) p = 0;
			else if (r == 1) p = $urandom_range(gen_cps, POS_TOP);
			else if (r < 6) begin
				// close to the previous query so the cache gets reused
				p = ((c == CMD_FWD) ? gen_fwd : gen_back) + int'($urandom_range(0, 6)) - 3;
				if (p < 1) p = 1;
				if (p > POS_TOP) p = POS_TOP;
			end else p = $urandom_range(1, gen_cps + 2);
			if (c == CMD_FWD) gen_fwd = p;
			else gen_back = p;
			push_query(c, p);
		end
	endtask

	initial begin
		logic [7:0] mixed [12];
		int         start;
		int         k;

		arst_n             = 1'b0;
		req.valid          = 1'b0;
		req.cmd            = CMD_LOAD;
		req.data_byte      = 8'h00;
		req.last_byte      = 1'b0;
		req.query_position = '0;
		rsp.ready          = 1'b0;

		// empty record after reset, then the unused command
		push_query(CMD_FWD, 0);
		push_query(CMD_BACK, 0);
		push_query(CMD_FWD, POS_TOP - 1);
		push_query(CMD_BACK, POS_TOP);
		push_item(CMD_NONE, 8'hFF, 1'b1, POS_TOP);

		push_load(8'h00, 1'b0);
		push_load(8'h7F, 1'b1);
		push_query(CMD_FWD, POS_TOP);
		push_query(CMD_BACK, 1);

		// two, three and four byte characters, a bad lead, a stray continuation
		mixed = '{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
				8'hFF, 8'h80, 8'h41};
		for (k = 0; k < 12; k++) push_load(mixed[k], k == 11);
		push_query(CMD_FWD, 3);
		push_query(CMD_FWD, 2);
		push_query(CMD_BACK, 2);
		push_query(CMD_BACK, 1);
		push_query(CMD_FWD, POS_TOP);
		push_query(CMD_BACK, POS_TOP);
		gen_cps = 6;

		start = n_total;
		while (n_total - n_noise - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 29) == 0) begin
				push_item(CMD_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						$urandom_range(0, POS_TOP));
				n_noise++;
			end
			push_record(($urandom_range(0, 7) == 0) ? $urandom_range(25, 120)
					: $urandom_range(1, 24),
					($urandom_range(0, 9) < 2) ? 0 : (($urandom_range(0, 4) == 0) ? 2 : 1));
			push_queries($urandom_range(4, 20));
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (n_taken != n_total || expected_offsets.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_bad == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------------
	// driver: bursts of transfers with random gaps
	// ------------------------------------------------------------------------
	logic      req_took = 1'b0;
	req_item_t drv_item;
	int        tx_burst = 1;
	int        tx_gap   = 0;

	always @(negedge clk) begin
		if (arst_n && (!req.valid || req_took)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				req.valid <= 1'b0;
			end else if (request_backlog.size() > 0) begin
				drv_item = request_backlog.pop_front();
				req.cmd            <= drv_item.cmd;
				req.data_byte      <= drv_item.data_byte;
				req.last_byte      <= drv_item.last_byte;
				req.query_position <= drv_item.query_position;
				req.valid          <= 1'b1;
				if (tx_burst <= 1) begin
					tx_burst = $urandom_range(1, 40);
					tx_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else tx_burst--;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// receiver: stall pattern plus one long hold-off
	// ------------------------------------------------------------------------
	bit hold_off = 1'b0;
	int rx_mode  = 0;
	int rx_left  = 0;

	initial begin
		wait (n_taken >= HOLD_AT);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(10, 80);
		end else rx_left--;
		if (hold_off || !arst_n) rsp.ready <= 1'b0;
		else begin
			case (rx_mode)
				2:       rsp.ready <= 1'($urandom_range(0, 1));
				3:       rsp.ready <= ($urandom_range(0, 4) == 0);
				default: rsp.ready <= 1'b1;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// monitor: predicts on each request transfer, checks each result transfer
	// ------------------------------------------------------------------------
	logic [OFF_W-1:0] exp_off;

	task automatic note_mismatch(input string what, input logic [OFF_W-1:0] want,
			input logic [OFF_W-1:0] got);
		n_bad++;
		if (n_bad <= 10)
			$display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	always @(posedge clk) begin
		req_took <= req.valid && req.ready;
		if (req.valid && req.ready) begin
			n_taken++;
			case (req.cmd)
				CMD_LOAD: take_byte(req.data_byte, req.last_byte);
				CMD_FWD:  expected_offsets.push_back(OFF_W'(fwd_offset(req.query_position)));
				CMD_BACK: expected_offsets.push_back(OFF_W'(back_offset(req.query_position)));
				default:  ;
			endcase
		end
		if (rsp.valid && rsp.ready) begin
			if (expected_offsets.size() == 0) begin
				note_mismatch("result with no query pending", 'x, rsp.byte_offset);
			end else begin
				exp_off = expected_offsets.pop_front();
				if (rsp.byte_offset !== exp_off)
					note_mismatch("byte_offset mismatch", exp_off, rsp.byte_offset);
			end
		end
	end

endmodule
